// ----- rtl/ipfns_pkg.sv -----
// ----------------------------------------------------------------------------
// ipfns_pkg
// Shared constants and types for the in-place four-neighbor smoothing block.
// ----------------------------------------------------------------------------
package ipfns_pkg;

  // Widths of the frame coordinates and of the size registers.
  localparam int RowW = 11;
  localparam int ColW = 11;
  localparam int CfgW = 12;

  // Size limits and defaults of the frame.
  localparam int MinSize        = 3;
  localparam int MaxSize        = 2048;
  localparam int DefFrameWidth  = 1920;
  localparam int DefFrameHeight = 1080;

  // Defaults of the top-level parameters.
  localparam int MaxWidthDef  = 2048;
  localparam int PixelBitsDef = 16;

  // Register indexes on the configuration port.
  localparam logic RegFrameWidth  = 1'b0;
  localparam logic RegFrameHeight = 1'b1;
  localparam int   PaddrW         = 3;

  // Depth of the result queue; it must take two results on top of the
  // entries that may still wait.
  localparam int ResDepth = 4;

  // Position and framing flags of one result.
  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            last;
    logic            done;
  } res_tag_t;

endpackage

// ----- rtl/ipfns_line_buf.sv -----
// ----------------------------------------------------------------------------
// ipfns_line_buf
// Line buffers for the original previous row and the smoothed row above.
// ----------------------------------------------------------------------------
module ipfns_line_buf #(
  parameter int DataW = 16,
  parameter int Depth = 2048,
  parameter int AddrW = 11
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic             wr_smooth_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_orig_i,
  input  logic [DataW-1:0] wr_smooth_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] orig_cur_o,
  output logic [DataW-1:0] orig_nxt_o,
  output logic [DataW-1:0] smooth_cur_o
);

  logic [DataW-1:0] orig_mem [Depth];
  logic [DataW-1:0] smooth_mem [Depth];
  logic [AddrW-1:0] rd_addr_nxt;
  logic [DataW-1:0] orig_cur_q, orig_nxt_q, smooth_cur_q;

  // The column after the read address; past the last entry it wraps, and
  // that value is never used.
  assign rd_addr_nxt = rd_addr_i + AddrW'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      orig_mem[wr_addr_i] <= wr_orig_i;
    end
    orig_cur_q <= orig_mem[rd_addr_i];
    orig_nxt_q <= orig_mem[rd_addr_nxt];
  end

  always_ff @(posedge clk_i) begin
    if (wr_smooth_en_i) begin
      smooth_mem[wr_addr_i] <= wr_smooth_i;
    end
    smooth_cur_q <= smooth_mem[rd_addr_i];
  end

  assign orig_cur_o   = orig_cur_q;
  assign orig_nxt_o   = orig_nxt_q;
  assign smooth_cur_o = smooth_cur_q;

endmodule

// ----- rtl/ipfns_res_fifo.sv -----
// ----------------------------------------------------------------------------
// ipfns_res_fifo
// Result queue that takes up to two results per cycle and hands out one beat.
// ----------------------------------------------------------------------------
module ipfns_res_fifo import ipfns_pkg::*; #(
  parameter int PixelBits = PixelBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push0_i,
  input  logic                 push1_i,
  input  logic [PixelBits-1:0] pix0_i,
  input  res_tag_t             tag0_i,
  input  logic [PixelBits-1:0] pix1_i,
  input  res_tag_t             tag1_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [PixelBits-1:0] out_pix_o,
  output res_tag_t             out_tag_o
);

  localparam int PtrW = $clog2(ResDepth);
  localparam int CntW = $clog2(ResDepth + 1);

  logic [PixelBits-1:0] pix_q [ResDepth];
  res_tag_t             tag_q [ResDepth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nxt;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 pop;

  assign pop        = (cnt_q != '0) && !out_stall_i;
  assign wr_ptr_nxt = wr_ptr_q + PtrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push0_i) + PtrW'(push1_i);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    cnt_d    = cnt_q + CntW'(push0_i) + CntW'(push1_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // The second result of an item always goes right behind the first.
  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      pix_q[wr_ptr_q] <= pix0_i;
      tag_q[wr_ptr_q] <= tag0_i;
    end
    if (push1_i) begin
      pix_q[wr_ptr_nxt] <= pix1_i;
      tag_q[wr_ptr_nxt] <= tag1_i;
    end
  end

  assign room_o      = cnt_q <= CntW'(ResDepth - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_pix_o   = pix_q[rd_ptr_q];
  assign out_tag_o   = tag_q[rd_ptr_q];

endmodule

// ----- rtl/in_place_four_neighbor_smoothing_top.sv -----
// ----------------------------------------------------------------------------
// in_place_four_neighbor_smoothing_top
// Four-neighbor mean smoothing of a raster frame with in-place semantics.
// ----------------------------------------------------------------------------
// Results are registered in the result queue as their pixel is taken.
// Throughput: one pixel per cycle while the result queue has room; on the
// last row each pixel yields two results, so the single output beat per
// cycle holds the input back there. The line buffers are read one column ahead.
// Reset: position, left neighbor and result queue clear; the size registers
// return to 1920 by 1080. The line buffers are not cleared.
// ----------------------------------------------------------------------------
module in_place_four_neighbor_smoothing_top import ipfns_pkg::*; #(
  parameter int MaxWidth  = MaxWidthDef,
  parameter int PixelBits = PixelBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration port.
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PaddrW-1:0]    paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // Pixel input channel.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PixelBits-1:0] pixel_i,
  // Result output channel.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [PixelBits-1:0] out_pixel_o,
  output logic [RowW-1:0]      out_row_o,
  output logic [ColW-1:0]      out_col_o,
  output logic                 last_of_item_o,
  output logic                 frame_done_o
);

  // Line buffer depth: MaxWidth, but at most MaxSize; the width in use is clamped to it.
  localparam int Depth = (MaxWidth < MaxSize) ? MaxWidth : MaxSize;
  localparam int AddrW = $clog2(Depth);

  // Size registers as written, and the clamped sizes in use.
  logic [CfgW-1:0] frame_width_q, frame_height_q;
  logic [CfgW-1:0] eff_w, eff_h, w_last, h_last;
  logic            cfg_wr;

  // Position of the next pixel and the last smoothed value of the row.
  logic [RowW-1:0]      row_q, row_d;
  logic [ColW-1:0]      col_q, col_d;
  logic [PixelBits-1:0] left_q, left_d;

  // Neighbors read from the line buffers for the current column.
  logic [PixelBits-1:0] orig_cur, orig_nxt, smooth_cur;

  logic                 accept, room;
  logic                 has_up, last_row, border, last_col;
  logic [PixelBits+1:0] sum;
  logic [PixelBits-1:0] val;
  logic [ColW-1:0]      rd_col;
  res_tag_t             up_tag, own_tag, tag0, out_tag;
  logic [PixelBits-1:0] pix0;

  // --------------------------------------------------------------------------
  // Configuration registers. Any write restarts the frame at the top-left
  // pixel. The port never waits.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= CfgW'(DefFrameWidth);
      frame_height_q <= CfgW'(DefFrameHeight);
    end else if (cfg_wr) begin
      case (paddr[2])
        RegFrameWidth:  frame_width_q  <= pwdata[CfgW-1:0];
        RegFrameHeight: frame_height_q <= pwdata[CfgW-1:0];
        default:        frame_width_q  <= frame_width_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegFrameWidth:  prdata = {{(32-CfgW){1'b0}}, frame_width_q};
      RegFrameHeight: prdata = {{(32-CfgW){1'b0}}, frame_height_q};
      default:        prdata = '0;
    endcase
  end

  // Out-of-range sizes are clamped; the width also to the line buffer depth.
  always_comb begin
    if (frame_width_q < CfgW'(MinSize)) begin
      eff_w = CfgW'(MinSize);
    end else if (frame_width_q > CfgW'(Depth)) begin
      eff_w = CfgW'(Depth);
    end else begin
      eff_w = frame_width_q;
    end
    if (frame_height_q < CfgW'(MinSize)) begin
      eff_h = CfgW'(MinSize);
    end else if (frame_height_q > CfgW'(MaxSize)) begin
      eff_h = CfgW'(MaxSize);
    end else begin
      eff_h = frame_height_q;
    end
  end

  assign w_last = eff_w - CfgW'(1);
  assign h_last = eff_h - CfgW'(1);

  // --------------------------------------------------------------------------
  // Per-pixel work. A pixel at (r, c) releases pixel (r-1, c) of the row
  // above. That pixel is copied on the border; in the interior it is the
  // truncated mean of the smoothed value above it, the smoothed value to its
  // left, and the originals below it (the incoming pixel) and to its right.
  // A pixel of the last row is a border pixel and also releases itself.
  // --------------------------------------------------------------------------
  assign accept   = in_valid_i && !in_stall_o;
  assign has_up   = row_q != '0;
  assign last_row = {1'b0, row_q} == h_last;
  assign last_col = {1'b0, col_q} == w_last;
  assign border   = (row_q == RowW'(1)) || (col_q == '0) || last_col;

  assign sum = {2'b00, smooth_cur} + {2'b00, pixel_i} + {2'b00, left_q}
             + {2'b00, orig_nxt};
  assign val = border ? orig_cur : sum[PixelBits+1:2];

  always_comb begin
    up_tag.row  = row_q - RowW'(1);
    up_tag.col  = col_q;
    up_tag.last = !last_row;
    up_tag.done = 1'b0;
    own_tag.row  = row_q;
    own_tag.col  = col_q;
    own_tag.last = 1'b1;
    own_tag.done = last_col;
    // The first result is the pixel above when there is one, else the
    // pixel itself; the second result is always the pixel itself.
    tag0 = has_up ? up_tag : own_tag;
    pix0 = has_up ? val : pixel_i;
  end

  // Position update; a configuration write restarts the frame.
  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    left_d = left_q;
    if (cfg_wr) begin
      row_d  = '0;
      col_d  = '0;
      left_d = '0;
    end else if (accept) begin
      if (has_up) begin
        left_d = val;
      end
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      left_q <= '0;
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      left_q <= left_d;
    end
  end

  // --------------------------------------------------------------------------
  // Line buffers. They are read at the column that comes next, so the read
  // data registered at an edge always belongs to the column held after it.
  // The write of the same edge goes to the column just left, not to one that
  // is read, unless a configuration write restarts the frame at that edge.
  // --------------------------------------------------------------------------
  assign rd_col = col_d;

  ipfns_line_buf #(
    .DataW (PixelBits),
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_line_buf (
    .clk_i          (clk_i),
    .wr_en_i        (accept),
    .wr_smooth_en_i (accept && has_up),
    .wr_addr_i      (col_q[AddrW-1:0]),
    .wr_orig_i      (pixel_i),
    .wr_smooth_i    (val),
    .rd_addr_i      (rd_col[AddrW-1:0]),
    .orig_cur_o     (orig_cur),
    .orig_nxt_o     (orig_nxt),
    .smooth_cur_o   (smooth_cur)
  );

  // --------------------------------------------------------------------------
  // Result queue. A pixel is taken only while two entries are free, so the
  // input side never waits on the output stall within the same cycle.
  // --------------------------------------------------------------------------
  ipfns_res_fifo #(
    .PixelBits (PixelBits)
  ) u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push0_i     (accept && (has_up || last_row)),
    .push1_i     (accept && has_up && last_row),
    .pix0_i      (pix0),
    .tag0_i      (tag0),
    .pix1_i      (pixel_i),
    .tag1_i      (own_tag),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_pix_o   (out_pixel_o),
    .out_tag_o   (out_tag)
  );

  assign in_stall_o     = !room;
  assign out_row_o      = out_tag.row;
  assign out_col_o      = out_tag.col;
  assign last_of_item_o = out_tag.last;
  assign frame_done_o   = out_tag.done;

endmodule
